>>> rtl/bpq_pkg.sv
// shared types and constants of the bounded priority queue
package bpq_pkg;

  localparam int CAP_W = 5;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_PULL  = 2'd1,
    CMD_FLUSH = 2'd2
  } command_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

>>> rtl/bpq_in_if.sv
// request channel of the bounded priority queue
interface bpq_in_if #(
  parameter int DATA_WIDTH = 32,
  parameter int PRIO_WIDTH = 8
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic [DATA_WIDTH-1:0]        data_word;
  logic signed [PRIO_WIDTH-1:0] priority_req;

  modport source (output valid, command, data_word, priority_req, input ready);
  modport sink (input valid, command, data_word, priority_req, output ready);
endinterface

>>> rtl/bpq_out_if.sv
// result channel of the bounded priority queue
interface bpq_out_if #(
  parameter int DATA_WIDTH = 32,
  parameter int OCC_W      = 5
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] data_out;
  logic [1:0]            status;
  logic [OCC_W-1:0]      occupancy;
  logic                  last;

  modport source (output valid, data_out, status, occupancy, last, input ready);
  modport sink (input valid, data_out, status, occupancy, last, output ready);
endinterface

>>> rtl/bpq_cell.sv
// one slot of the sorted chain: compares, holds, or shifts by one place
module bpq_cell
  import bpq_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int PRIO_WIDTH = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cell_ctl_t                    ctl,
  input  logic [DATA_WIDTH-1:0]        new_word,
  input  logic signed [PRIO_WIDTH-1:0] new_prio,
  input  logic                         prev_keep,
  input  logic                         prev_valid,
  input  logic [DATA_WIDTH-1:0]        prev_word,
  input  logic signed [PRIO_WIDTH-1:0] prev_prio,
  input  logic                         next_valid,
  input  logic [DATA_WIDTH-1:0]        next_word,
  input  logic signed [PRIO_WIDTH-1:0] next_prio,
  output logic                         valid,
  output logic [DATA_WIDTH-1:0]        word,
  output logic signed [PRIO_WIDTH-1:0] prio,
  output logic                         keep
);

  // entry stays ahead of the new item
  assign keep = valid && !new_prio[PRIO_WIDTH-1] &&
                (prio[PRIO_WIDTH-1] || (prio >= new_prio));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.push && !keep) begin
      valid <= prev_keep ? 1'b1 : prev_valid;
    end else if (ctl.pop) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !keep) begin
      word <= prev_keep ? new_word : prev_word;
      prio <= prev_keep ? new_prio : prev_prio;
    end else if (ctl.pop) begin
      word <= next_word;
      prio <= next_prio;
    end
  end

endmodule

>>> rtl/bounded_priority_queue.sv
// top level of the bounded priority queue
// A queue of up to DEPTH words, each tagged with a signed priority and kept
// in service order in a chain of compare cells. A push or a pull gives one
// result; every cell compares its priority with the new one at once, so the
// insertion point is found in the same cycle. A flush gives one result per
// cycle while the result channel accepts it, one for each held word (or a
// single empty result), and the request channel is held off until its last
// transfer has been loaded. Otherwise a request transfer is taken only when
// the output register is empty or its result leaves in the same cycle, so a
// result that waits holds off the request channel. The capacity register may
// be written only while the queue is idle.
module bounded_priority_queue
  import bpq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int PRIO_WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  bpq_in_if.sink           request,
  bpq_out_if.source        result
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             flushing;
  logic             flushing_next;

  logic                  out_valid;
  logic                  out_valid_next;
  logic [DATA_WIDTH-1:0] data_out;
  logic [DATA_WIDTH-1:0] data_out_next;
  status_t               status;
  status_t               status_next;
  logic [CNT_W-1:0]      occupancy;
  logic [CNT_W-1:0]      occupancy_next;
  logic                  last;
  logic                  last_next;

  logic      load;
  logic      take;
  logic      flush_step;
  logic      full;
  cell_ctl_t ctl;

  logic                         cell_valid [DEPTH];
  logic [DATA_WIDTH-1:0]        cell_word  [DEPTH];
  logic signed [PRIO_WIDTH-1:0] cell_prio  [DEPTH];
  logic                         cell_keep  [DEPTH];

  assign load       = !out_valid || result.ready;
  assign request.ready = !flushing && load;
  assign take       = request.valid && request.ready;
  assign flush_step = flushing && load;
  assign full       = (CMP_W'(count) >= CMP_W'(capacity)) || (count == CNT_W'(DEPTH));

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                         p_keep;
    logic                         p_valid;
    logic [DATA_WIDTH-1:0]        p_word;
    logic signed [PRIO_WIDTH-1:0] p_prio;
    logic                         n_valid;
    logic [DATA_WIDTH-1:0]        n_word;
    logic signed [PRIO_WIDTH-1:0] n_prio;

    if (i == 0) begin : g_head
      assign p_keep  = 1'b1;
      assign p_valid = 1'b0;
      assign p_word  = '0;
      assign p_prio  = '0;
    end else begin : g_body
      assign p_keep  = cell_keep[i-1];
      assign p_valid = cell_valid[i-1];
      assign p_word  = cell_word[i-1];
      assign p_prio  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_word  = '0;
      assign n_prio  = '0;
    end else begin : g_inner
      assign n_valid = cell_valid[i+1];
      assign n_word  = cell_word[i+1];
      assign n_prio  = cell_prio[i+1];
    end

    bpq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .PRIO_WIDTH (PRIO_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_word   (request.data_word),
      .new_prio   (request.priority_req),
      .prev_keep  (p_keep),
      .prev_valid (p_valid),
      .prev_word  (p_word),
      .prev_prio  (p_prio),
      .next_valid (n_valid),
      .next_word  (n_word),
      .next_prio  (n_prio),
      .valid      (cell_valid[i]),
      .word       (cell_word[i]),
      .prio       (cell_prio[i]),
      .keep       (cell_keep[i])
    );
  end

  always_comb begin
    ctl            = '0;
    count_next     = count;
    flushing_next  = flushing;
    out_valid_next = out_valid;
    data_out_next  = data_out;
    status_next    = status;
    occupancy_next = occupancy;
    last_next      = last;

    if (flush_step) begin
      ctl.pop        = 1'b1;
      count_next     = count - 1'b1;
      flushing_next  = (count != CNT_W'(1));
      out_valid_next = 1'b1;
      data_out_next  = cell_word[0];
      status_next    = ST_OK;
      occupancy_next = count - 1'b1;
      last_next      = (count == CNT_W'(1));
    end else if (take) begin
      out_valid_next = 1'b1;
      last_next      = 1'b1;
      data_out_next  = '0;
      occupancy_next = count;
      status_next    = ST_OK;
      unique case (request.command)
        CMD_PUSH: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            ctl.push       = 1'b1;
            count_next     = count + 1'b1;
            occupancy_next = count + 1'b1;
          end
        end
        CMD_PULL, CMD_FLUSH: begin
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            ctl.pop        = 1'b1;
            count_next     = count - 1'b1;
            occupancy_next = count - 1'b1;
            data_out_next  = cell_word[0];
            if (request.command == CMD_FLUSH) begin
              flushing_next = (count != CNT_W'(1));
              last_next     = (count == CNT_W'(1));
            end
          end
        end
        default: begin
          out_valid_next = 1'b0;
        end
      endcase
    end else if (load) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_W'(16);
      count     <= '0;
      flushing  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      count     <= count_next;
      flushing  <= flushing_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data_out  <= data_out_next;
    status    <= status_next;
    occupancy <= occupancy_next;
    last      <= last_next;
  end

  assign result.valid     = out_valid;
  assign result.data_out  = data_out;
  assign result.status    = status;
  assign result.occupancy = occupancy;
  assign result.last      = last;

endmodule
